// File: rtl/rls_pkg.sv
// ----------------------------------------------------------------------------
// rls_pkg
// Types, codes and arithmetic helpers shared by the Richardson solver files.
// ----------------------------------------------------------------------------
`default_nettype none
package rls_pkg;

  localparam int MAX_ORDER_DEF = 64;

  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_SOLVE  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] CFG_ORDER = 2'd0;
  localparam logic [1:0] CFG_STEP  = 2'd1;
  localparam logic [1:0] CFG_TOL   = 2'd2;
  localparam logic [1:0] CFG_LIMIT = 2'd3;

  localparam logic [6:0]  ORDER_RST = 7'd64;
  localparam logic [15:0] STEP_RST  = 16'd655;
  localparam logic [47:0] TOL_RST   = 48'd28147;
  localparam logic [19:0] LIMIT_RST = 20'd100000;

  typedef struct packed {
    logic [1:0]         op;
    logic [5:0]         row;
    logic [5:0]         column;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [5:0]         index;
    logic signed [31:0] solution;
    logic               last;
    logic               converged;
    logic [19:0]        iterations;
  } rsp_t;

  typedef struct packed {
    logic        ld_a;
    logic        ld_b;
    logic        init_vld;
    logic        prod_vld;
    logic [1:0]  prod_sel;
    logic        mac_vld;
    logic        mac_first;
    logic        mac_last;
    logic        row0;
    logic        upd_vld;
    logic        out_rd;
    logic        out_ld;
    logic        out_last;
    logic        converged;
    logic [19:0] iterations;
    logic [5:0]  i;
    logic [5:0]  j;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic below;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) r = 32'sh7fffffff;
    else if (v < -50'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [49:0] sx50(input logic [31:0] v);
    return $signed({{18{v[31]}}, v});
  endfunction

  function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic [64:0] s;
    logic signed [63:0] r;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) r = s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    else r = s[63:0];
    return r;
  endfunction

  function automatic logic [63:0] uadd64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/rls_datapath.sv
// ----------------------------------------------------------------------------
// rls_datapath
// Stores, multiply-accumulate pipeline, norms, threshold product and update.
// ----------------------------------------------------------------------------
`default_nettype none
module rls_datapath import rls_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire req_t        req,
  input  wire cmd_t        cmd,
  input  wire logic [15:0] step_size,
  input  wire logic [47:0] tolerance_squared,
  output status_t          status,
  output rsp_t             rsp
);

  localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int AW = $clog2(DEPTH);

  logic [31:0] mat [DEPTH];
  logic [31:0] rhs [MAX_ORDER];
  logic [31:0] xs  [MAX_ORDER];
  logic [31:0] res [MAX_ORDER];

  logic [IW-1:0] ci, cj, xaddr;
  logic [AW-1:0] ld_addr, rd_addr;
  logic row_ok, col_ok;

  logic s1_mac, s1_first, s1_last, s1_row0, s1_init, s1_upd;
  logic [IW-1:0] s1_i;
  logic signed [31:0] a_rd, x_rd, b_rd, r_rd;

  logic s2_mac, s2_first, s2_last, s2_row0, s2_init, s2_upd;
  logic [IW-1:0] s2_i;
  logic signed [63:0] prod;
  logic [63:0] bsq;
  logic signed [31:0] s2_b, s2_x;
  logic signed [48:0] dprod;

  logic s3_last, s3_row0;
  logic [IW-1:0] s3_i;
  logic signed [63:0] acc;
  logic signed [31:0] s3_b;

  logic s4_vld, s4_row0, s5_vld, s5_row0;
  logic signed [31:0] r_q;
  logic [63:0] sq, norm, rhsn;

  logic pp_vld, pp_first;
  logic [1:0] pp_sel;
  logic [55:0] pp_q;
  logic [111:0] thr, pp_sh;

  logic signed [49:0] acc_rnd, d_rnd;
  logic signed [31:0] resid, x_new;
  logic [23:0] tol_part;
  logic [31:0] nrm_part;

  assign ci = cmd.i[IW-1:0];
  assign cj = cmd.j[IW-1:0];
  assign xaddr = cmd.mac_vld ? cj : ci;
  assign row_ok = {1'b0, req.row} < 7'(MAX_ORDER);
  assign col_ok = {1'b0, req.column} < 7'(MAX_ORDER);
  assign ld_addr = AW'(req.row) * AW'(MAX_ORDER) + AW'(req.column);
  assign rd_addr = AW'(ci) * AW'(MAX_ORDER) + AW'(cj);

  always_ff @(posedge clk) begin
    if (cmd.ld_a && row_ok && col_ok) mat[ld_addr] <= req.value;
    if (cmd.ld_b && row_ok) rhs[req.row[IW-1:0]] <= req.value;
    a_rd <= mat[rd_addr];
    b_rd <= rhs[ci];
    r_rd <= res[ci];
    x_rd <= xs[xaddr];
    if (cmd.init_vld) xs[ci] <= '0;
    else if (s2_upd) xs[s2_i] <= x_new;
    if (s3_last) res[s3_i] <= resid;
  end

  always_comb begin
    acc_rnd = $signed({{2{acc[63]}}, acc[63:16]}) + $signed({49'b0, acc[15]});
    resid = sat32(sx50(sat32(acc_rnd)) - sx50(s3_b));
    d_rnd = $signed({{17{dprod[48]}}, dprod[48:16]}) + $signed({49'b0, dprod[15]});
    x_new = sat32(sx50(s2_x) - d_rnd);
    tol_part = cmd.prod_sel[0] ? tolerance_squared[47:24] : tolerance_squared[23:0];
    nrm_part = cmd.prod_sel[1] ? rhsn[63:32] : rhsn[31:0];
    case (pp_sel)
      2'd0:    pp_sh = 112'(pp_q);
      2'd1:    pp_sh = 112'(pp_q) << 24;
      2'd2:    pp_sh = 112'(pp_q) << 32;
      default: pp_sh = 112'(pp_q) << 56;
    endcase
  end

  always_ff @(posedge clk) begin
    s1_first <= cmd.mac_first;
    s1_last  <= cmd.mac_last;
    s1_row0  <= cmd.row0;
    s1_i     <= ci;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_row0  <= s1_row0;
    s2_i     <= s1_i;
    s2_b     <= b_rd;
    s2_x     <= x_rd;
    prod     <= a_rd * x_rd;
    bsq      <= b_rd * b_rd;
    dprod    <= $signed({1'b0, step_size}) * r_rd;
    if (s2_mac) begin
      acc <= s2_first ? prod : sadd64(acc, prod);
    end
    s3_row0 <= s2_row0;
    s3_i    <= s2_i;
    s3_b    <= s2_b;
    if (s2_init) rhsn <= s2_row0 ? bsq : uadd64(rhsn, bsq);
    r_q     <= resid;
    s4_row0 <= s3_row0;
    sq      <= r_q * r_q;
    s5_row0 <= s4_row0;
    if (s5_vld) norm <= s5_row0 ? sq : uadd64(norm, sq);
    pp_q     <= tol_part * nrm_part;
    pp_sel   <= cmd.prod_sel;
    pp_first <= cmd.prod_sel == 2'd0;
    if (pp_vld) thr <= (pp_first ? 112'd0 : thr) + pp_sh;
    if (cmd.out_ld) begin
      rsp.index      <= 6'(ci);
      rsp.solution   <= x_rd;
      rsp.last       <= cmd.out_last;
      rsp.converged  <= cmd.converged;
      rsp.iterations <= cmd.iterations;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_mac <= 1'b0; s1_init <= 1'b0; s1_upd <= 1'b0;
      s2_mac <= 1'b0; s2_init <= 1'b0; s2_upd <= 1'b0;
      s3_last <= 1'b0; s4_vld <= 1'b0; s5_vld <= 1'b0; pp_vld <= 1'b0;
    end else begin
      s1_mac  <= cmd.mac_vld;
      s1_init <= cmd.init_vld;
      s1_upd  <= cmd.upd_vld;
      s2_mac  <= s1_mac;
      s2_init <= s1_init;
      s2_upd  <= s1_upd;
      s3_last <= s2_mac && s2_last;
      s4_vld  <= s3_last;
      s5_vld  <= s4_vld;
      pp_vld  <= cmd.prod_vld;
    end
  end

  assign status.busy = s1_mac | s1_init | s1_upd | s2_mac | s2_init | s2_upd |
                       s3_last | s4_vld | s5_vld | pp_vld;
  assign status.below = {norm, 48'b0} < thr;

endmodule
`default_nettype wire

// File: rtl/rls_ctrl.sv
// ----------------------------------------------------------------------------
// rls_ctrl
// Sequencer for load, solve phases, convergence decision and result output.
// ----------------------------------------------------------------------------
`default_nettype none
module rls_ctrl import rls_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire logic [1:0]  req_op,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  input  wire logic [6:0]  order,
  input  wire logic [19:0] iteration_limit,
  input  wire status_t     status,
  output cmd_t             cmd
);

  localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_INIT    = 12'b000000000010,
    S_INIT_DR = 12'b000000000100,
    S_PROD    = 12'b000000001000,
    S_RES     = 12'b000000010000,
    S_RES_DR  = 12'b000000100000,
    S_CHECK   = 12'b000001000000,
    S_UPD     = 12'b000010000000,
    S_UPD_DR  = 12'b000100000000,
    S_OUT_RD  = 12'b001000000000,
    S_OUT_LD  = 12'b010000000000,
    S_OUT_WT  = 12'b100000000000
  } state_t;

  state_t state, state_next;
  logic [IW-1:0] i, i_next, j, j_next, last_idx;
  logic [1:0] k, k_next;
  logic [19:0] count, count_next;
  logic done, done_next;
  logic [6:0] n7;
  logic i_last, j_last, req_acc;

  assign n7 = (order == 7'd0) ? 7'd1 : (order > 7'(MAX_ORDER)) ? 7'(MAX_ORDER) : order;
  assign last_idx = IW'(n7 - 7'd1);
  assign i_last = i == last_idx;
  assign j_last = j == last_idx;
  assign req_ready = state == S_IDLE;
  assign rsp_valid = state == S_OUT_WT;
  assign req_acc = req_valid && req_ready;

  always_comb begin
    state_next = state;
    i_next = i;
    j_next = j;
    k_next = k;
    count_next = count;
    done_next = done;
    cmd = '0;
    cmd.i = 6'(i);
    cmd.j = 6'(j);
    cmd.prod_sel = k;
    cmd.out_last = i_last;
    cmd.converged = done;
    cmd.iterations = count;
    unique case (state)
      S_IDLE: begin
        cmd.ld_a = req_acc && req_op == OP_LOAD_A;
        cmd.ld_b = req_acc && req_op == OP_LOAD_B;
        if (req_acc && req_op == OP_SOLVE) begin
          state_next = S_INIT;
          i_next = '0;
          count_next = '0;
        end
      end
      S_INIT: begin
        cmd.init_vld = 1'b1;
        cmd.row0 = i == '0;
        if (i_last) state_next = S_INIT_DR;
        else i_next = i + 1'b1;
      end
      S_INIT_DR: begin
        if (!status.busy) begin
          state_next = S_PROD;
          k_next = '0;
        end
      end
      S_PROD: begin
        cmd.prod_vld = 1'b1;
        k_next = k + 1'b1;
        if (k == 2'd3) begin
          state_next = S_RES;
          i_next = '0;
          j_next = '0;
        end
      end
      S_RES: begin
        cmd.mac_vld = 1'b1;
        cmd.mac_first = j == '0;
        cmd.mac_last = j_last;
        cmd.row0 = i == '0;
        if (j_last) begin
          j_next = '0;
          if (i_last) state_next = S_RES_DR;
          else i_next = i + 1'b1;
        end else begin
          j_next = j + 1'b1;
        end
      end
      S_RES_DR: begin
        if (!status.busy) state_next = S_CHECK;
      end
      S_CHECK: begin
        done_next = status.below;
        i_next = '0;
        if (status.below || count >= iteration_limit) state_next = S_OUT_RD;
        else state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd_vld = 1'b1;
        if (i_last) state_next = S_UPD_DR;
        else i_next = i + 1'b1;
      end
      S_UPD_DR: begin
        if (!status.busy) begin
          count_next = count + 1'b1;
          state_next = S_RES;
          i_next = '0;
          j_next = '0;
        end
      end
      S_OUT_RD: begin
        cmd.out_rd = 1'b1;
        state_next = S_OUT_LD;
      end
      S_OUT_LD: begin
        cmd.out_ld = 1'b1;
        state_next = S_OUT_WT;
      end
      S_OUT_WT: begin
        if (rsp_ready) begin
          if (i_last) state_next = S_IDLE;
          else begin
            i_next = i + 1'b1;
            state_next = S_OUT_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i <= '0;
      j <= '0;
      k <= '0;
      count <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      i <= i_next;
      j <= j_next;
      k <= k_next;
      count <= count_next;
      done <= done_next;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && rsp_valid)) else $error("request taken while result pending");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_ready && i_last) |=> req_ready)
    else $error("not idle after final result");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (count <= iteration_limit || done))
    else $error("iteration count beyond limit");
  a_drain_clean: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> !status.busy) else $error("check with pipeline busy");

endmodule
`default_nettype wire

// File: rtl/richardson_linear_solver_top.sv
// ----------------------------------------------------------------------------
// richardson_linear_solver_top
// Richardson iteration solver for Ax=b in Q16.16 with configuration registers.
// ----------------------------------------------------------------------------
// Load items: one per cycle while no solve is running, no result.
// Solve: setup forms the right-hand norm and threshold product, then each check
//   runs the residual through the single multiply-accumulate pipeline, drains it
//   and compares; each update pass also waits for the pipeline to drain.
// Output: each result element passes through read, load and wait states; the next starts once the receiver takes it.
// Reset: synchronous, restores register defaults; stores hold no reset value.
`default_nettype none
module richardson_linear_solver_top import rls_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire req_t        req,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output rsp_t             rsp,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);

  logic [6:0]  order;
  logic [15:0] step_size;
  logic [47:0] tolerance_squared;
  logic [19:0] iteration_limit;
  cmd_t cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      order <= ORDER_RST;
      step_size <= STEP_RST;
      tolerance_squared <= TOL_RST;
      iteration_limit <= LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ORDER: order <= cfg_data[6:0];
        CFG_STEP:  step_size <= cfg_data[15:0];
        CFG_TOL:   tolerance_squared <= cfg_data;
        CFG_LIMIT: iteration_limit <= cfg_data[19:0];
        default:   order <= order;
      endcase
    end
  end

  rls_ctrl #(.MAX_ORDER(MAX_ORDER)) u_ctrl (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req_op(req.op),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .order(order), .iteration_limit(iteration_limit),
    .status(status), .cmd(cmd)
  );

  rls_datapath #(.MAX_ORDER(MAX_ORDER)) u_dp (
    .clk(clk), .rst(rst), .req(req), .cmd(cmd),
    .step_size(step_size), .tolerance_squared(tolerance_squared),
    .status(status), .rsp(rsp)
  );

endmodule
`default_nettype wire

// File: test/tb.sv
// ----------------------------------------------------------------------------
// Richardson solver testbench
// Loads matrix and right-hand items, runs solves under several register
// settings and compares every emitted solution element with a local model.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
  import rls_pkg::*;

  localparam int N_MAX = 64;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_ITEMS = 435;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_ORDER;
  logic [47:0] cfg_data = '0;

  richardson_linear_solver_top i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  logic signed [31:0] a_mem [N_MAX*N_MAX];
  logic signed [31:0] b_mem [N_MAX];
  logic signed [31:0] x_mem [N_MAX];
  logic signed [31:0] r_mem [N_MAX];
  bit a_set [N_MAX*N_MAX];
  bit b_set [N_MAX];
  logic [6:0]  m_order = ORDER_RST;
  logic [15:0] m_step = STEP_RST;
  logic [47:0] m_tol = TOL_RST;
  logic [19:0] m_limit = LIMIT_RST;

  rsp_t solution_q [$];
  int errors = 0;
  int cycles = 0;
  int items_sent = 0;
  int send_idle = 0;
  int recv_idle = 0;

  function automatic int active_n();
    if (m_order == 0) return 1;
    if (m_order > N_MAX) return N_MAX;
    return int'(m_order);
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint add_sat64(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7fff_ffff_ffff_ffff) return 64'sh7fff_ffff_ffff_ffff;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return s[63:0];
  endfunction

  function automatic logic [63:0] add_usat64(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  function automatic longint round_q16(longint v);
    longint q;
    q = v >>> 16;
    if (v[15:0] >= 16'h8000) q = q + 1;
    return q;
  endfunction

  function automatic logic [63:0] square(logic signed [31:0] v);
    longint w;
    w = longint'(v);
    return 64'(w * w);
  endfunction

  function automatic bit residual_below(int n, logic [63:0] b_norm);
    logic [63:0] norm;
    logic [127:0] lhs, rhs;
    longint acc;
    norm = '0;
    for (int i = 0; i < n; i++) begin
      acc = 0;
      for (int j = 0; j < n; j++)
        acc = add_sat64(acc, longint'(a_mem[i*N_MAX+j]) * longint'(x_mem[j]));
      r_mem[i] = clip32(longint'(clip32(round_q16(acc))) - longint'(b_mem[i]));
      norm = add_usat64(norm, square(r_mem[i]));
    end
    lhs = {64'b0, norm} << 48;
    rhs = {80'b0, m_tol} * {64'b0, b_norm};
    return lhs < rhs;
  endfunction

  task automatic predict_solution(req_t it);
    int n;
    logic [63:0] b_norm;
    logic [19:0] count;
    bit done;
    rsp_t e;
    case (it.op)
      OP_LOAD_A: begin
        a_mem[it.row*N_MAX+it.column] = it.value;
        a_set[it.row*N_MAX+it.column] = 1'b1;
      end
      OP_LOAD_B: begin
        b_mem[it.row] = it.value;
        b_set[it.row] = 1'b1;
      end
      OP_SOLVE: begin
        n = active_n();
        b_norm = '0;
        count = '0;
        for (int i = 0; i < N_MAX; i++) x_mem[i] = '0;
        for (int i = 0; i < n; i++) b_norm = add_usat64(b_norm, square(b_mem[i]));
        forever begin
          done = residual_below(n, b_norm);
          if (done || count >= m_limit) break;
          for (int i = 0; i < n; i++)
            x_mem[i] = clip32(longint'(x_mem[i])
                              - round_q16(longint'({1'b0, m_step}) * longint'(r_mem[i])));
          count++;
        end
        for (int i = 0; i < n; i++) begin
          e.index = 6'(i);
          e.solution = x_mem[i];
          e.last = (i == n - 1);
          e.converged = done;
          e.iterations = count;
          solution_q.push_back(e);
        end
      end
      default: ;
    endcase
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp_valid && rsp_ready) begin
      if (solution_q.size() == 0) begin
        report("unexpected item index", 64'(rsp.index), 64'h0);
      end else begin
        e = solution_q.pop_front();
        if (rsp.index !== e.index) report("index", 64'(rsp.index), 64'(e.index));
        if (rsp.solution !== e.solution)
          report("solution", 64'(rsp.solution), 64'(e.solution));
        if (rsp.last !== e.last) report("last", 64'(rsp.last), 64'(e.last));
        if (rsp.converged !== e.converged)
          report("converged", 64'(rsp.converged), 64'(e.converged));
        if (rsp.iterations !== e.iterations)
          report("iterations", 64'(rsp.iterations), 64'(e.iterations));
      end
    end
  end

  always @(negedge clk) rsp_ready = ($urandom_range(99) >= recv_idle);

  task automatic send_item(logic [1:0] op, logic [5:0] row, logic [5:0] column,
                           logic [31:0] value);
    req_t it;
    it.op = op;
    it.row = row;
    it.column = column;
    it.value = value;
    while ($urandom_range(99) < send_idle) @(negedge clk);
    req = it;
    req_valid = 1'b1;
    do @(posedge clk); while (!req_ready);
    predict_solution(it);
    items_sent++;
    @(negedge clk);
    req_valid = 1'b0;
  endtask

  task automatic drain();
    while (solution_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [47:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ORDER: m_order = data[6:0];
      CFG_STEP:  m_step = data[15:0];
      CFG_TOL:   m_tol = data;
      default:   m_limit = data[19:0];
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(logic [6:0] ord, logic [15:0] step, logic [47:0] tol,
                           logic [19:0] lim);
    drain();
    write_reg(CFG_ORDER, 48'(ord));
    write_reg(CFG_STEP, 48'(step));
    write_reg(CFG_TOL, tol);
    write_reg(CFG_LIMIT, 48'(lim));
  endtask

  // diagonally dominant system with random content
  task automatic load_system(int n);
    logic [31:0] v;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        if (i == j) v = 32'h10000 + $urandom_range(0, 16'h4000);
        else v = 32'($signed($urandom_range(0, 16'h1000)) - 32'sh800);
        send_item(OP_LOAD_A, 6'(i), 6'(j), v);
      end
      send_item(OP_LOAD_B, 6'(i), 6'($urandom), 32'($signed($urandom_range(0, 32'h80000))
                - 32'sh40000));
    end
  endtask

  task automatic fill_missing(int n);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++)
        if (!a_set[i*N_MAX+j]) send_item(OP_LOAD_A, 6'(i), 6'(j), $urandom);
      if (!b_set[i]) send_item(OP_LOAD_B, 6'(i), 6'($urandom), $urandom);
    end
  endtask

  task automatic test_extremes();
    configure(7'd2, 16'hffff, 48'hffff_ffff_ffff, 20'hfffff);
    send_item(OP_LOAD_A, 6'd0, 6'd0, 32'h10000);
    send_item(OP_LOAD_A, 6'd0, 6'd1, 32'h0);
    send_item(OP_LOAD_A, 6'd1, 6'd0, 32'h0);
    send_item(OP_LOAD_A, 6'd1, 6'd1, 32'h10000);
    send_item(OP_LOAD_B, 6'd0, 6'd63, 32'h7fffffff);
    send_item(OP_LOAD_B, 6'd1, 6'd0, 32'h80000000);
    send_item(OP_SOLVE, 6'd63, 6'd63, 32'hffffffff);
    send_item(OP_LOAD_A, 6'd63, 6'd63, 32'h80000000);
    send_item(OP_LOAD_A, 6'd62, 6'd1, 32'h7fffffff);
  endtask

  task automatic test_unknown_op();
    send_item(OP_NONE, 6'd0, 6'd0, 32'h12345678);
    send_item(OP_NONE, 6'd63, 6'd63, 32'hffffffff);
    send_item(OP_SOLVE, 6'd0, 6'd0, 32'h0);
  endtask

  task automatic test_limit_zero_order_zero();
    configure(7'd0, 16'h8000, 48'h10_0000, 20'd0);
    send_item(OP_SOLVE, 6'd5, 6'd9, 32'h0);
  endtask

  task automatic test_zero_rhs();
    configure(7'd2, 16'h8000, 48'hffff_ffff_ffff, 20'd5);
    send_item(OP_LOAD_B, 6'd0, 6'd0, 32'h0);
    send_item(OP_LOAD_B, 6'd1, 6'd0, 32'h0);
    send_item(OP_SOLVE, 6'd0, 6'd0, 32'h0);
  endtask

  task automatic test_random(int quota);
    int stop_at;
    int n;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      configure(($urandom_range(9) == 0) ? 7'd0 : 7'($urandom_range(1, 6)),
                ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(16'h6000,
                16'hffff)),
                ($urandom_range(3) == 0) ? 48'({$urandom, $urandom})
                                         : 48'($urandom_range(1, 32'h7ffffff)),
                20'($urandom_range(0, 40)));
      n = active_n();
      if ($urandom_range(4) != 0) load_system(n);
      repeat ($urandom_range(0, 4))
        send_item(($urandom_range(2) == 0) ? OP_NONE : 2'($urandom_range(0, 1)),
                  6'($urandom), 6'($urandom), $urandom);
      fill_missing(n);
      if ($urandom_range(3) == 0) drain();
      send_item(OP_SOLVE, 6'($urandom), 6'($urandom), $urandom);
      if ($urandom_range(1) == 0) send_item(OP_SOLVE, 6'($urandom), 6'($urandom), $urandom);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_extremes();
    test_unknown_op();
    test_limit_zero_order_zero();
    test_zero_rhs();
    send_idle = 26;
    recv_idle = 66;
    test_random(RANDOM_ITEMS / 3);
    send_idle = 66;
    recv_idle = 26;
    test_random(RANDOM_ITEMS / 3);
    send_idle = 0;
    recv_idle = 0;
    test_random(RANDOM_ITEMS / 3);
    while (solution_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
rtl/rls_pkg.sv
rtl/rls_datapath.sv
rtl/rls_ctrl.sv
rtl/richardson_linear_solver_top.sv
test/tb.sv
